### hw/rtl/tfe_pkg.sv
// Shared types and constants for the two-band FIR equalizer.
// Used by tfe_mac and the top level; depends on nothing else.
`timescale 1ns / 1ps

package tfe_pkg;

   localparam int TYPE_W     = 2;   // request type field
   localparam int SAMPLE_W   = 16;  // audio sample width
   localparam int COEF_W     = 16;  // Q1.15 coefficient width
   localparam int IDX_W      = 6;   // coefficient index field
   localparam int PROD_W     = SAMPLE_W + COEF_W;  // one tap product
   localparam int PAIR_W     = PROD_W + 1;         // low plus high product
   localparam int FRAC_SHIFT = 14;  // Q1.15 product doubled, then >> 15

   localparam logic [TYPE_W-1:0] REQ_SAMPLE    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_LOW_COEF  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_HIGH_COEF = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_SCALE,
      ST_EMIT
   } tfe_state_type;

   typedef struct packed {
      logic start;      // a sample transaction was accepted: clear the accumulator
      logic issue;      // memory reads for one tap were issued this cycle
      logic low_on;     // low band takes part in the sum
      logic high_on;    // high band takes part in the sum
      logic scale;      // turn the accumulator into the result
      logic load_pass;  // result is the input sample itself
   } tfe_mac_ctrl_type;

endpackage

### hw/rtl/tfe_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
// Stand-alone; holds the sample history and both coefficient stores.
`timescale 1ns / 1ps

module tfe_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tfe_mac.sv
// Multiply-accumulate datapath: two tap products, their sum, the accumulator,
// and the final divide by 2^14 toward zero. Depends on tfe_pkg.
`timescale 1ns / 1ps

module tfe_mac #(
   parameter int ACC_W = 39
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  tfe_pkg::tfe_mac_ctrl_type               ctrl,
   input  logic signed [tfe_pkg::COEF_W-1:0]       low_coef,
   input  logic signed [tfe_pkg::COEF_W-1:0]       high_coef,
   input  logic signed [tfe_pkg::SAMPLE_W-1:0]     hist,
   input  logic signed [tfe_pkg::SAMPLE_W-1:0]     pass_sample,
   output logic                                    busy,
   output logic signed [ACC_W-tfe_pkg::FRAC_SHIFT-1:0] result
);

   import tfe_pkg::*;

   localparam int RW = ACC_W - FRAC_SHIFT;
   localparam logic [ACC_W-1:0] BIAS = ACC_W'((1 << FRAC_SHIFT) - 1);

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [PROD_W-1:0] prod_lo_ff, prod_hi_ff;
   logic signed [PAIR_W-1:0] pair_ff, pair_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  biased;
   logic signed [RW-1:0]     res_ff;

   // Stage valids: memory data, products, pair sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= ctrl.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_comb begin
      pair_in = '0;
      if (ctrl.low_on) begin
         pair_in = pair_in + PAIR_W'(prod_lo_ff);
      end
      if (ctrl.high_on) begin
         pair_in = pair_in + PAIR_W'(prod_hi_ff);
      end
   end

   assign acc_in = acc_ff + {{(ACC_W-PAIR_W){pair_ff[PAIR_W-1]}}, pair_ff};
   // Adding 2^14 - 1 to a negative sum makes the arithmetic shift round toward zero.
   assign biased = acc_ff + (acc_ff[ACC_W-1] ? BIAS : '0);

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         prod_lo_ff <= low_coef * hist;
         prod_hi_ff <= high_coef * hist;
      end
      if (v2_ff) begin
         pair_ff <= pair_in;
      end
      if (ctrl.start) begin
         acc_ff <= '0;
      end else if (v3_ff) begin
         acc_ff <= acc_in;
      end
      if (ctrl.load_pass) begin
         res_ff <= {{(RW-SAMPLE_W){pass_sample[SAMPLE_W-1]}}, pass_sample};
      end else if (ctrl.scale) begin
         res_ff <= biased[ACC_W-1:FRAC_SHIFT];
      end
   end

   assign busy   = v1_ff | v2_ff | v3_ff;
   assign result = res_ff;

endmodule

### hw/rtl/two_band_fir_equalizer_top.sv
// Top level of the two-band FIR equalizer: control sequencer, history and
// coefficient memories, output register. Depends on tfe_pkg, tfe_ram, tfe_mac.
`timescale 1ns / 1ps

// Usage
// The request channel (req_*) carries three kinds of transaction: an audio sample,
// a low-band coefficient load and a high-band coefficient load. A transaction is
// taken at a clock edge where req_valid is high and req_stall is low. Each audio
// sample yields one response transaction on rsp_* (sample_out and saturated);
// loads and the unused request type yield none.
// A coefficient load leaves the block idle, ready for the next request. A sample with a band
// enabled walks the history one tap per cycle, reading one history word and one
// word from each coefficient memory per cycle; the sequencer then drains the MAC
// pipeline, scales the accumulator and delivers the response. A sample with both
// bands off takes the input sample itself as the result. No new request is taken
// until the sequencer is back in the idle state.
// Reset (synchronous, active high) starts a clearing pass over every address that
// writes zero into every memory entry; req_stall stays high throughout it.
// Output: the response sits in a register. While the receiver stalls, it holds
// and the block still takes the next request; the sequencer waits to deliver a
// new result only if the register is still occupied.

module two_band_fir_equalizer_top #(
   parameter int TAPS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tfe_pkg::TYPE_W-1:0]           req_type,
   input  logic signed [tfe_pkg::SAMPLE_W-1:0]  req_sample_in,
   input  logic                                 req_low_band_on,
   input  logic                                 req_high_band_on,
   input  logic [tfe_pkg::IDX_W-1:0]            req_coef_index,
   input  logic signed [tfe_pkg::COEF_W-1:0]    req_coef_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tfe_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   output logic                                 rsp_saturated
);

   import tfe_pkg::*;

   localparam int AW    = $clog2(TAPS);
   // Worst case is 2 * TAPS products of magnitude 2^30.
   localparam int ACC_W = PAIR_W + AW + 1;
   localparam int RW    = ACC_W - FRAC_SHIFT;
   localparam logic [AW-1:0]    LAST    = AW'(TAPS - 1);
   localparam logic signed [RW-1:0] RES_MAX = RW'(32767);
   localparam logic signed [RW-1:0] RES_MIN = RW'(-32768);

   tfe_state_type state_ff, state_in;

   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] wpos_ff, wpos_in, wpos_inc;
   logic [AW-1:0] tap_ff, tap_in;
   logic [AW-1:0] hidx_ff, hidx_in, hidx_inc;
   logic          low_ff, low_in;
   logic          high_ff, high_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_sample_out_ff, rsp_sample_out_in;
   logic                        rsp_saturated_ff, rsp_saturated_in;

   logic            accept, is_sample, is_low, is_high, coef_ok, clearing, out_load;
   logic [AW-1:0]   coef_addr;
   logic            hist_we, low_we, high_we;
   logic [AW-1:0]   hist_waddr, coef_waddr;
   logic [SAMPLE_W-1:0] hist_wdata;
   logic [COEF_W-1:0]   coef_wdata;

   logic [SAMPLE_W-1:0] hist_rdata;
   logic [COEF_W-1:0]   low_rdata, high_rdata;

   tfe_mac_ctrl_type     mac_ctrl;
   logic                 mac_busy;
   logic signed [RW-1:0] mac_result;

   // Request decode. The block takes requests only in the idle state.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_sample = (req_type == REQ_SAMPLE);
   assign is_low    = (req_type == REQ_LOW_COEF);
   assign is_high   = (req_type == REQ_HIGH_COEF);
   // The index field can name taps past the end of a short filter; such loads drop.
   assign coef_ok   = (int'(req_coef_index) < TAPS);
   assign coef_addr = AW'(req_coef_index);
   assign clearing  = (state_ff == ST_CLEAR);

   assign wpos_inc = (wpos_ff == LAST) ? '0 : wpos_ff + 1'b1;
   assign hidx_inc = (hidx_ff == LAST) ? '0 : hidx_ff + 1'b1;

   // Memory write ports: the clearing pass, or the accepted transaction.
   assign hist_we    = clearing || (accept && is_sample);
   assign hist_waddr = clearing ? clr_ff : wpos_ff;
   assign hist_wdata = clearing ? '0 : req_sample_in;
   assign low_we     = clearing || (accept && is_low && coef_ok);
   assign high_we    = clearing || (accept && is_high && coef_ok);
   assign coef_waddr = clearing ? clr_ff : coef_addr;
   assign coef_wdata = clearing ? '0 : req_coef_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wpos_ff      <= wpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff            <= tap_in;
      hidx_ff           <= hidx_in;
      low_ff            <= low_in;
      high_ff           <= high_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
      rsp_saturated_ff  <= rsp_saturated_in;
   end

   // Sequencer: next state, counters and datapath controls.
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      wpos_in   = wpos_ff;
      tap_in    = tap_ff;
      hidx_in   = hidx_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      out_load  = 1'b0;

      mac_ctrl           = '0;
      mac_ctrl.low_on    = low_ff;
      mac_ctrl.high_on   = high_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST) begin
               clr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && is_sample) begin
               // The slot after the newest sample holds the oldest one.
               wpos_in  = wpos_inc;
               hidx_in  = wpos_inc;
               tap_in   = '0;
               low_in   = req_low_band_on;
               high_in  = req_high_band_on;
               mac_ctrl.start = 1'b1;
               if (req_low_band_on || req_high_band_on) begin
                  state_in = ST_RUN;
               end else begin
                  mac_ctrl.load_pass = 1'b1;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_RUN: begin
            mac_ctrl.issue = 1'b1;
            tap_in  = tap_ff + 1'b1;
            hidx_in = hidx_inc;
            if (tap_ff == LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            mac_ctrl.scale = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Wait only while an earlier response is still held by the receiver.
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register with clipping to the 16-bit range.
   always_comb begin
      rsp_sample_out_in = rsp_sample_out_ff;
      rsp_saturated_in  = rsp_saturated_ff;
      if (out_load) begin
         if (mac_result > RES_MAX) begin
            rsp_sample_out_in = RES_MAX[SAMPLE_W-1:0];
            rsp_saturated_in  = 1'b1;
         end else if (mac_result < RES_MIN) begin
            rsp_sample_out_in = RES_MIN[SAMPLE_W-1:0];
            rsp_saturated_in  = 1'b1;
         end else begin
            rsp_sample_out_in = mac_result[SAMPLE_W-1:0];
            rsp_saturated_in  = 1'b0;
         end
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;
   assign rsp_saturated  = rsp_saturated_ff;

   tfe_ram #(
      .DEPTH (TAPS),
      .WIDTH (SAMPLE_W)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_en   (mac_ctrl.issue),
      .rd_addr (hidx_ff),
      .rd_data (hist_rdata)
   );

   tfe_ram #(
      .DEPTH (TAPS),
      .WIDTH (COEF_W)
   ) u_low_ram (
      .clock   (clock),
      .wr_en   (low_we),
      .wr_addr (coef_waddr),
      .wr_data (coef_wdata),
      .rd_en   (mac_ctrl.issue),
      .rd_addr (tap_ff),
      .rd_data (low_rdata)
   );

   tfe_ram #(
      .DEPTH (TAPS),
      .WIDTH (COEF_W)
   ) u_high_ram (
      .clock   (clock),
      .wr_en   (high_we),
      .wr_addr (coef_waddr),
      .wr_data (coef_wdata),
      .rd_en   (mac_ctrl.issue),
      .rd_addr (tap_ff),
      .rd_data (high_rdata)
   );

   tfe_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (mac_ctrl),
      .low_coef    (low_rdata),
      .high_coef   (high_rdata),
      .hist        (hist_rdata),
      .pass_sample (req_sample_in),
      .busy        (mac_busy),
      .result      (mac_result)
   );

endmodule

### hw/rtl/tfe_checker.sv
// Port-level checks for the two-band FIR equalizer, bound to its top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module tfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_sample_out,
   input logic        rsp_saturated
);

   // A held response keeps its contents until the receiver takes it.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out)
                                 && $stable(rsp_saturated))
      else $error("response changed while stalled");

   // A clipped result sits exactly at one of the two 16-bit bounds.
   a_sat_bound: assert property (@(posedge clock)
      rsp_valid && rsp_saturated |-> (rsp_sample_out == 16'h7fff ||
                                      rsp_sample_out == 16'h8000))
      else $error("saturated flag with an unclipped value");

   // Reset drops any response and starts the clearing pass.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("reset did not clear the response or start clearing");

endmodule

bind two_band_fir_equalizer_top tfe_checker u_tfe_checker (.*);

### bench/tb_two_band_fir_equalizer_top.sv
// Self-checking testbench for two_band_fir_equalizer_top: directed and random traffic
// checked against an in-bench model of the equalizer. Depends on tfe_pkg and the RTL.
`timescale 1ns / 1ps

module tb_two_band_fir_equalizer_top;

   import tfe_pkg::*;

   // The fourth request code is never decoded by the block; it must be dropped silently.
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam int NTAPS = 64;
   // Time scale for the final drain wait, taken from a banded sample's run.
   localparam int SAMPLE_LATENCY = NTAPS + 7;

   typedef struct {
      logic [TYPE_W-1:0]          kind;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       low_on;
      logic                       high_on;
      logic [IDX_W-1:0]           idx;
      logic signed [COEF_W-1:0]   coef;
   } eq_item_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] value;
      logic                       clipped;
   } eq_result_type;

   // Clock, reset and the ports of the block. All inputs start at known values.
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [TYPE_W-1:0]          req_type = REQ_SAMPLE;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       req_low_band_on = 1'b0;
   logic                       req_high_band_on = 1'b0;
   logic [IDX_W-1:0]           req_coef_index = '0;
   logic signed [COEF_W-1:0]   req_coef_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_saturated;

   // Private copy of the equalizer state, updated once per accepted transaction.
   logic signed [SAMPLE_W-1:0] sample_history [NTAPS];
   logic signed [COEF_W-1:0]   low_taps [NTAPS];
   logic signed [COEF_W-1:0]   high_taps [NTAPS];
   logic [IDX_W-1:0]           history_wpos;

   // Equalizer outputs that the model has produced but the block has not yet delivered.
   eq_result_type expected_out_q [$];

   // Handshake pacing, in percent of cycles.
   int send_idle_pct = 0;
   int rcv_stall_pct = 0;

   // Bookkeeping for the summary and the verdict.
   int error_count = 0;
   int n_samples = 0;
   int n_loads = 0;
   int n_ignored = 0;
   int n_clipped = 0;
   int n_checked = 0;

   two_band_fir_equalizer_top #(.TAPS(NTAPS)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_sample_in    (req_sample_in),
      .req_low_band_on  (req_low_band_on),
      .req_high_band_on (req_high_band_on),
      .req_coef_index   (req_coef_index),
      .req_coef_value   (req_coef_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_saturated    (rsp_saturated)
   );

   // 20 ns clock.
   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #(64'd80_000_000);
      $display("** two_band_fir_equalizer_top: FAILED **");
      $finish;
   end

   // One line per mismatch, capped so that a badly broken block does not flood the log.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (error_count < 100) begin
         $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      end
      error_count++;
   endtask

   // Model of the equalizer. A sample is stored at the write pointer first, so the
   // oldest entry is the one just after it, and coefficient 0 weights that entry.
   // The sum is kept at full precision, divided by 16384 with truncation toward zero
   // (signed integer division does exactly that) and then clipped to 16 bits.
   task automatic predict_equalizer(input eq_item_type it);
      longint           acc;
      longint           quot;
      logic [IDX_W-1:0] oldest;
      logic [IDX_W-1:0] slot;
      eq_result_type    res;
      case (it.kind)
         REQ_LOW_COEF: begin
            // A 6-bit index is always below TAPS, so every load lands.
            low_taps[it.idx] = it.coef;
            n_loads++;
         end
         REQ_HIGH_COEF: begin
            high_taps[it.idx] = it.coef;
            n_loads++;
         end
         REQ_SAMPLE: begin
            sample_history[history_wpos] = it.sample;
            oldest = history_wpos + 1'b1;
            res.clipped = 1'b0;
            if (it.low_on || it.high_on) begin
               acc = 0;
               for (int t = 0; t < NTAPS; t++) begin
                  slot = oldest + IDX_W'(t);
                  if (it.low_on) begin
                     acc += longint'(low_taps[t]) * longint'(sample_history[slot]);
                  end
                  if (it.high_on) begin
                     acc += longint'(high_taps[t]) * longint'(sample_history[slot]);
                  end
               end
               quot = acc / 16384;
               if (quot > 32767) begin
                  quot = 32767;
                  res.clipped = 1'b1;
               end else if (quot < -32768) begin
                  quot = -32768;
                  res.clipped = 1'b1;
               end
               res.value = quot[SAMPLE_W-1:0];
            end else begin
               res.value = it.sample;
            end
            history_wpos = oldest;
            expected_out_q.push_back(res);
            n_samples++;
            if (res.clipped) begin
               n_clipped++;
            end
         end
         default: begin
            n_ignored++;
         end
      endcase
   endtask

   // Drives one request transaction. Inputs change at the falling edge only, and
   // req_valid gets a single assignment per falling edge: it is lowered only for an
   // idle cycle and raised again no earlier than the next falling edge.
   task automatic send_item(input eq_item_type it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_type         <= it.kind;
      req_sample_in    <= it.sample;
      req_low_band_on  <= it.low_on;
      req_high_band_on <= it.high_on;
      req_coef_index   <= it.idx;
      req_coef_value   <= it.coef;
      req_valid        <= 1'b1;
      // The payload holds until a rising edge sees the block not stalling.
      do begin
         @(posedge clock);
      end while (req_stall);
      predict_equalizer(it);
   endtask

   function automatic eq_item_type random_item();
      eq_item_type it;
      it.kind    = TYPE_W'($urandom_range(3));
      it.sample  = SAMPLE_W'($urandom);
      it.low_on  = 1'($urandom_range(1));
      it.high_on = 1'($urandom_range(1));
      it.idx     = IDX_W'($urandom);
      it.coef    = COEF_W'($urandom);
      return it;
   endfunction

   // Full-scale a quarter of the time, otherwise shrunk by an arithmetic shift so that
   // plenty of filter outputs stay inside the 16-bit range.
   function automatic logic signed [15:0] scaled_value();
      logic signed [15:0] v;
      v = 16'($urandom);
      if ($urandom_range(3) != 0) begin
         v = v >>> $urandom_range(15);
      end
      return v;
   endfunction

   function automatic eq_item_type make_item(input logic [TYPE_W-1:0] kind,
                                             input logic signed [15:0] sample,
                                             input logic lo, input logic hi,
                                             input logic [IDX_W-1:0] idx,
                                             input logic signed [15:0] coef);
      eq_item_type it;
      it = random_item();
      it.kind    = kind;
      it.sample  = sample;
      it.low_on  = lo;
      it.high_on = hi;
      it.idx     = idx;
      it.coef    = coef;
      return it;
   endfunction

   // Result checker: every accepted response is matched with the oldest expectation.
   always @(posedge clock) begin
      eq_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out_q.size() == 0) begin
            report_mismatch("response with no sample outstanding",
                            longint'(rsp_sample_out), longint'(0));
         end else begin
            want = expected_out_q.pop_front();
            n_checked++;
            if (rsp_sample_out !== want.value) begin
               report_mismatch("sample_out", longint'(rsp_sample_out),
                               longint'(want.value));
            end
            if (rsp_saturated !== want.clipped) begin
               report_mismatch("saturated", longint'(rsp_saturated),
                               longint'(want.clipped));
            end
         end
      end
   end

   // Receiver back-pressure, redrawn at every falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
   end

   // Right after reset every store is zero, so a filtered sample must come out as zero.
   task automatic test_reset_state();
      send_item(make_item(REQ_SAMPLE, 16'sh7FFF, 1'b1, 1'b1, 6'd0, 16'sd0));
      send_item(make_item(REQ_SAMPLE, -16'sh8000, 1'b1, 1'b0, 6'd63, 16'sd0));
   endtask

   // With both band bits clear the input comes straight back, extremes included,
   // and the history pointer still moves on.
   task automatic test_passthrough();
      send_item(make_item(REQ_SAMPLE, -16'sh8000, 1'b0, 1'b0, 6'd0, 16'sd0));
      send_item(make_item(REQ_SAMPLE, 16'sh7FFF, 1'b0, 1'b0, 6'd63, 16'sd0));
      send_item(make_item(REQ_SAMPLE, 16'sh5555, 1'b0, 1'b0, 6'd21, 16'sd0));
      send_item(make_item(REQ_SAMPLE, 16'shAAAA, 1'b0, 1'b0, 6'd42, 16'sd0));
   endtask

   // The newest sample sits under coefficient 63. Full-scale weights drive the sum past
   // both rails, a small negative sum must truncate toward zero rather than down,
   // and opposite bands that nearly cancel must be added before the one truncation.
   task automatic test_rounding_and_clipping();
      send_item(make_item(REQ_LOW_COEF, 16'sd0, 1'b0, 1'b0, 6'd63, 16'sh7FFF));
      send_item(make_item(REQ_SAMPLE, 16'sh7FFF, 1'b1, 1'b0, 6'd0, 16'sd0));
      send_item(make_item(REQ_SAMPLE, -16'sh8000, 1'b1, 1'b0, 6'd0, 16'sd0));
      send_item(make_item(REQ_SAMPLE, -16'sd1, 1'b1, 1'b0, 6'd0, 16'sd0));
      send_item(make_item(REQ_HIGH_COEF, 16'sd0, 1'b0, 1'b0, 6'd63, -16'sh8000));
      send_item(make_item(REQ_SAMPLE, 16'sd1000, 1'b1, 1'b1, 6'd0, 16'sd0));
      send_item(make_item(REQ_SAMPLE, -16'sd1000, 1'b1, 1'b1, 6'd0, 16'sd0));
      send_item(make_item(REQ_SAMPLE, -16'sh8000, 1'b0, 1'b1, 6'd0, 16'sd0));
      // Coefficient 0 weights the oldest history entry.
      send_item(make_item(REQ_LOW_COEF, 16'sd0, 1'b0, 1'b0, 6'd0, -16'sh8000));
      send_item(make_item(REQ_SAMPLE, 16'sd300, 1'b1, 1'b0, 6'd0, 16'sd0));
   endtask

   // The unused request code must leave every store and the pointer untouched.
   task automatic test_ignored_requests();
      eq_item_type it;
      it = random_item();
      it.kind = REQ_UNUSED;
      send_item(it);
      it = random_item();
      it.kind = REQ_UNUSED;
      send_item(it);
      send_item(make_item(REQ_SAMPLE, 16'sh1234, 1'b1, 1'b1, 6'd0, 16'sd0));
      send_item(make_item(REQ_SAMPLE, -16'sh1234, 1'b0, 1'b0, 6'd0, 16'sd0));
   endtask

   // Random traffic shaped like real use: coefficient updates, occasionally a whole
   // bank, between bursts of audio, plus a sprinkling of unused request codes.
   task automatic run_random_phase(input int n_items, input int idle_pct,
                                   input int stall_pct);
      int          sent;
      int          pick;
      int          burst;
      int          shift;
      logic        lo;
      logic        hi;
      eq_item_type it;
      send_idle_pct = idle_pct;
      rcv_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            it = random_item();
            it.kind = REQ_UNUSED;
            send_item(it);
         end else if (pick < 12) begin
            it = random_item();
            it.kind = $urandom_range(1) ? REQ_LOW_COEF : REQ_HIGH_COEF;
            shift = $urandom_range(15);
            for (int i = 0; i < NTAPS; i++) begin
               it.idx = IDX_W'(i);
               it.coef = $signed(16'($urandom)) >>> shift;
               send_item(it);
            end
            sent += NTAPS;
         end else if (pick < 35) begin
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst; i++) begin
               it = random_item();
               it.kind = $urandom_range(1) ? REQ_LOW_COEF : REQ_HIGH_COEF;
               it.coef = scaled_value();
               send_item(it);
            end
            sent += burst;
         end else begin
            burst = $urandom_range(1, 24);
            lo = 1'($urandom_range(1));
            hi = 1'($urandom_range(1));
            for (int i = 0; i < burst; i++) begin
               it = random_item();
               it.kind = REQ_SAMPLE;
               it.sample = scaled_value();
               if ($urandom_range(7) != 0) begin
                  it.low_on = lo;
                  it.high_on = hi;
               end
               send_item(it);
            end
            sent += burst;
         end
      end
   endtask

   // Four pacing phases: free flowing, sender mostly idle, receiver mostly stalling,
   // and light idling on both sides.
   task automatic test_random_traffic();
      run_random_phase(500, 0, 0);
      run_random_phase(500, 68, 0);
      run_random_phase(500, 0, 68);
      run_random_phase(500, 7, 7);
   endtask

   initial begin
      int            guard;
      eq_result_type left;
      for (int i = 0; i < NTAPS; i++) begin
         sample_history[i] = '0;
         low_taps[i] = '0;
         high_taps[i] = '0;
      end
      history_wpos = '0;

      // Synchronous reset, released at a falling edge. The block then runs its memory
      // clearing pass with req_stall high, which send_item waits out.
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_passthrough();
      test_rounding_and_clipping();
      test_ignored_requests();
      test_random_traffic();

      @(negedge clock);
      req_valid <= 1'b0;
      rcv_stall_pct = 0;

      // Let every outstanding sample come back, then watch a while for strays.
      guard = 0;
      while (expected_out_q.size() != 0 && guard < 20 * SAMPLE_LATENCY) begin
         @(posedge clock);
         guard++;
      end
      repeat (2 * SAMPLE_LATENCY) @(posedge clock);
      while (expected_out_q.size() != 0) begin
         left = expected_out_q.pop_front();
         report_mismatch("sample never answered", longint'(0), longint'(left.value));
      end

      $display("Covered %0d audio samples (%0d clipped), %0d coefficient loads and %0d",
               n_samples, n_clipped, n_loads, n_ignored);
      $display("ignored requests over four pacing phases; %0d responses checked.",
               n_checked);
      if (error_count == 0) begin
         $display("** two_band_fir_equalizer_top: PASSED **");
      end else begin
         $display("** two_band_fir_equalizer_top: FAILED **");
      end
      $finish;
   end

endmodule
